// ===== rtl/keyframe_pose_interpolator_macros.svh =====
// Assertion macros shared by the checker.
`ifndef KEYFRAME_POSE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_POSE_INTERPOLATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KPI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define KPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kpi_pkg.sv =====
package kpi_pkg;
  localparam int MaxKeyframes = 64;
  localparam int SlotW = $clog2(MaxKeyframes);
  localparam int CountW = SlotW + 1;
  localparam int RatioBits = 24;
  localparam logic signed [17:0] PiQ13 = 18'sd25736;
  localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpQuery = 1'b1;

  localparam logic [0:0] RegLoopEnable = 1'b0;
  localparam logic [0:0] RegKeyframeCount = 1'b1;

  // Wraps an angle that lies within one turn of [-pi,pi) back into range.
  function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a >= PiQ13) r = a - TwoPiQ13;
    else if (a < -PiQ13) r = a + TwoPiQ13;
    return r;
  endfunction
endpackage

// ===== rtl/keyframe_pose_interpolator.sv =====
// Keyframe pose interpolator.
// Load beats (start with op low) write one keyframe into slot; they give no
// result and leave busy low. Query beats (op high) return one result beat,
// marked by done for one cycle, holding the pose and speed at query_time.
// busy is high while a query is in progress; start is ignored then.
// A query reads the first and last keyframe times, then walks the table one
// keyframe per cycle through a single comparator and memory read port.
// Looping adds the bit serial modulo; interpolating adds a set-up step, the
// bit serial ratio divide (both on one shared subtractor) and the multiply
// steps for x, y, speed and yaw. A new beat can be accepted in the cycle
// that shows the result. An empty table answers in the cycle after the
// accept, a single keyframe after the hold read and hold output states.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the
// user must make them only while the block is idle; the block does not enforce it.
// Reset clears the sequencer, done and the configuration registers; the keyframe
// table is not cleared and must be loaded before it is queried.
// The receiver cannot stall: each result beat is present for one cycle only.
module keyframe_pose_interpolator
  import kpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic [0:0]         op,
  input  logic [5:0]         slot,
  input  logic signed [31:0] key_time,
  input  logic signed [31:0] key_x,
  input  logic signed [31:0] key_y,
  input  logic signed [15:0] key_yaw,
  input  logic signed [15:0] key_speed,
  input  logic signed [31:0] query_time,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic signed [15:0] speed_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_MOD, S_MOD_FIX, S_SCAN, S_RD_PREV,
    S_DIV, S_MUL_X, S_MUL_Y, S_MUL_S, S_MUL_YAW, S_HOLD_RD, S_HOLD_OUT
  } state_t;

  typedef logic [127:0] entry_t;

  state_t state;
  entry_t mem [MaxKeyframes];
  entry_t rd;
  logic [SlotW-1:0] rd_addr;
  logic rd_en;

  logic loop_enable;
  logic [CountW-1:0] keyframe_count;
  logic [CountW-1:0] n;
  logic [CountW-1:0] idx;
  logic signed [32:0] t;
  logic signed [31:0] t0;
  logic signed [32:0] period;
  // shared serial divider: remainder, quotient and bit counter
  logic [32:0] rem;
  logic [32:0] num;
  logic [24:0] quo;
  logic [5:0]  step;
  logic signed [32:0] prev_t, prev_x, prev_y;
  logic signed [15:0] prev_yaw, prev_spd;
  logic signed [32:0] next_x, next_y;
  logic signed [17:0] dyaw;
  logic signed [15:0] next_spd;
  logic [24:0] ratio;
  logic signed [32:0] mul_a;
  logic signed [59:0] prod;
  logic signed [32:0] lerp_v;

  logic [CountW-1:0] n_sat;
  assign n_sat = (keyframe_count > CountW'(MaxKeyframes)) ? CountW'(MaxKeyframes)
                                                           : keyframe_count;
  assign busy = (state != S_IDLE);

  // Table memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (start && !busy && op == OpLoad) begin
      mem[slot] <= {key_time, key_x, key_y, key_yaw, key_speed};
    end
    if (rd_en) begin
      rd <= mem[rd_addr];
    end
  end

  logic signed [31:0] rd_t, rd_x, rd_y;
  logic signed [15:0] rd_yaw, rd_spd;
  assign rd_t = rd[127:96];
  assign rd_x = rd[95:64];
  assign rd_y = rd[63:32];
  assign rd_yaw = rd[31:16];
  assign rd_spd = rd[15:0];

  // The scan ends on the first keyframe or runs off the last one; rd moves on
  // at that edge, so the held keyframe is taken straight from it.
  logic scan_hold;
  logic done_next;
  assign scan_hold = (state == S_SCAN) &&
                     ((idx == CountW'(1) && t <= 33'(rd_t)) ||
                      (t > 33'(rd_t) && idx == n));
  assign done_next = scan_hold || state == S_MUL_YAW || state == S_HOLD_OUT ||
                     (state == S_IDLE && start && op == OpQuery && n_sat == '0);

  // One shared restoring subtract step.
  logic [32:0] div_d;
  logic [33:0] trial;
  assign div_d = period[32:0];
  assign trial = {rem, num[32]} - {1'b0, div_d};

  // Round-half-up lerp offset from the single multiplier.
  assign prod = mul_a * $signed({1'b0, ratio[24:0]});
  assign lerp_v = 33'(prod >>> RatioBits) + 33'(prod[RatioBits-1]);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    case (state)
      S_IDLE: begin
        rd_en = start;
        rd_addr = '0;
      end
      S_RD_FIRST: begin
        rd_en = 1'b1;
        rd_addr = SlotW'(n - 1'b1);
      end
      S_MOD_FIX, S_RD_LAST: begin
        rd_en = 1'b1;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en = 1'b1;
        rd_addr = SlotW'(idx);
      end
      S_HOLD_RD: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      loop_enable <= 1'b0;
      keyframe_count <= '0;
    end else begin
      done <= done_next;
      if (cfg_we) begin
        case (cfg_index)
          RegLoopEnable:    loop_enable <= cfg_data[0];
          RegKeyframeCount: keyframe_count <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start && op == OpQuery) begin
            n <= n_sat;
            t <= 33'(query_time);
            if (n_sat == '0) begin
              pos_x <= '0;
              pos_y <= '0;
              heading <= '0;
              speed_out <= '0;
            end else if (n_sat == CountW'(1)) begin
              state <= S_HOLD_RD;
            end else begin
              state <= S_RD_FIRST;
            end
          end
        end
        S_RD_FIRST: begin
          t0 <= rd_t;
          state <= S_RD_LAST;
        end
        S_RD_LAST: begin
          period <= 33'(rd_t) - 33'(t0);
          if (loop_enable && (33'(rd_t) - 33'(t0)) > 0) begin
            // magnitude of t - start, sign handled afterwards
            num <= (t - 33'(t0)) < 0 ? 33'(-(t - 33'(t0))) : 33'(t - 33'(t0));
            rem <= '0;
            step <= '0;
            state <= S_MOD;
          end else begin
            idx <= CountW'(1);
            state <= S_SCAN;
          end
        end
        S_MOD: begin
          if (!trial[33]) rem <= trial[32:0];
          else rem <= {rem[31:0], num[32]};
          num <= {num[31:0], 1'b0};
          step <= step + 1'b1;
          if (step == 6'd32) state <= S_MOD_FIX;
        end
        S_MOD_FIX: begin
          if ((t - 33'(t0)) < 0 && rem != '0) t <= 33'(t0) + (period - 33'(rem));
          else t <= 33'(t0) + 33'(rem);
          idx <= CountW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          // rd holds entry idx-1 here; the first test is against keyframe 0
          if (scan_hold) begin
            pos_x <= rd_x;
            pos_y <= rd_y;
            heading <= rd_yaw;
            speed_out <= rd_spd;
            state <= S_IDLE;
          end else if (idx != CountW'(1) && t <= 33'(rd_t)) begin
            state <= S_RD_PREV;
            next_x <= 33'(rd_x);
            next_y <= 33'(rd_y);
            next_spd <= rd_spd;
            period <= 33'(rd_t);
            dyaw <= 18'(rd_yaw);
          end else begin
            idx <= idx + 1'b1;
            prev_t <= 33'(rd_t);
            prev_x <= 33'(rd_x);
            prev_y <= 33'(rd_y);
            prev_yaw <= rd_yaw;
            prev_spd <= rd_spd;
          end
        end
        S_RD_PREV: begin
          period <= period - prev_t;
          dyaw <= wrap_once(dyaw - 18'(prev_yaw));
          if (period - prev_t > 0) begin
            num <= (t - prev_t) > (period - prev_t) ? period - prev_t : t - prev_t;
            rem <= '0;
            step <= '0;
            quo <= '0;
            state <= S_DIV;
          end else begin
            ratio <= '0;
            mul_a <= next_x - prev_x;
            state <= S_MUL_X;
          end
        end
        S_DIV: begin
          // numerator shifted by 2^24: feed its bits then zeros
          if (!trial[33]) begin
            rem <= trial[32:0];
            quo <= {quo[23:0], 1'b1};
          end else begin
            rem <= {rem[31:0], num[32]};
            quo <= {quo[23:0], 1'b0};
          end
          num <= {num[31:0], 1'b0};
          step <= step + 1'b1;
          if (step == 6'd56) begin
            ratio <= !trial[33] ? {quo[23:0], 1'b1} : {quo[23:0], 1'b0};
            mul_a <= next_x - prev_x;
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          pos_x <= 32'(prev_x + lerp_v);
          mul_a <= next_y - prev_y;
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          pos_y <= 32'(prev_y + lerp_v);
          mul_a <= 33'(next_spd) - 33'(prev_spd);
          state <= S_MUL_S;
        end
        S_MUL_S: begin
          speed_out <= 16'(33'(prev_spd) + lerp_v);
          mul_a <= 33'(dyaw);
          state <= S_MUL_YAW;
        end
        S_MUL_YAW: begin
          heading <= 16'(wrap_once(wrap_once(18'(prev_yaw) + 18'(lerp_v))));
          state <= S_IDLE;
        end
        S_HOLD_RD: begin
          state <= S_HOLD_OUT;
        end
        S_HOLD_OUT: begin
          pos_x <= rd_x;
          pos_y <= rd_y;
          heading <= rd_yaw;
          speed_out <= rd_spd;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/kpi_checker.sv =====
`include "keyframe_pose_interpolator_macros.svh"
module kpi_checker
  import kpi_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic [0:0] op
);
  logic load_beat;
  assign load_beat = start && !busy && op == OpLoad;

  // A result beat is only shown once the block is back at idle.
  `KPI_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result beat while busy")
  `KPI_ASSERT_NEXT(a_load_quiet, clk, rst, load_beat, !busy && !done, "load beat gave a result")
  `KPI_ASSERT_NEXT(a_idle_holds, clk, rst, !busy && !start, !busy && !done, "activity without a beat")
endmodule

bind keyframe_pose_interpolator kpi_checker u_kpi_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .op(op)
);
